### design/pvs_pkg.sv
`timescale 1ns / 1ps
// Package for the Phong vertex shader: widths, stage types, register indexes
// and the fixed-point helpers. No dependencies.
package pvs_pkg;

    localparam int NVEC   = 3;   // light, view, normal
    localparam int MAG_W  = 30;
    localparam int SUM_W  = 62;
    localparam int ROOT_W = 31;
    localparam int QUO_W  = 31;
    localparam int REM_W  = MAG_W + QUO_W - 1;
    localparam int WIDE_W = 74;
    localparam int UNIT_W = 31;

    localparam logic [2:0] CFG_LIGHT_X  = 3'd0;
    localparam logic [2:0] CFG_LIGHT_Y  = 3'd1;
    localparam logic [2:0] CFG_LIGHT_Z  = 3'd2;
    localparam logic [2:0] CFG_EYE_X    = 3'd3;
    localparam logic [2:0] CFG_EYE_Y    = 3'd4;
    localparam logic [2:0] CFG_EYE_Z    = 3'd5;
    localparam logic [2:0] CFG_MATERIAL = 3'd6;

    typedef struct packed {
        logic [NVEC-1:0][SUM_W-1:0]          rem;
        logic [NVEC-1:0][ROOT_W-1:0]         root;
        logic [NVEC-1:0][2:0][MAG_W-1:0]     mag;
        logic [NVEC-1:0][2:0]                neg;
    } t_sqrt;

    typedef struct packed {
        logic [NVEC-1:0][ROOT_W-1:0]         len;
        logic [NVEC-1:0][2:0][REM_W-1:0]     rem;
        logic [NVEC-1:0][2:0][QUO_W-1:0]     quo;
        logic [NVEC-1:0][2:0]                neg;
    } t_div;

    // signed divide by 2^30, truncating toward zero
    function automatic logic signed [WIDE_W-1:0] drop30(input logic signed [WIDE_W-1:0] s);
        logic [WIDE_W-1:0] mg;
        mg = s[WIDE_W-1] ? WIDE_W'(-s) : WIDE_W'(s);
        mg = mg >> 30;
        return s[WIDE_W-1] ? -$signed(mg) : $signed(mg);
    endfunction

    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [WIDE_W-1:0] k);
        logic signed [WIDE_W-1:0] one;
        one = WIDE_W'(1) <<< 30;
        if (k < 0) return '0;
        if (k > one) return UNIT_W'(one);
        return k[UNIT_W-1:0];
    endfunction

endpackage

### design/phong_vertex_shader.sv
`timescale 1ns / 1ps
// Phong vertex shader top level: deep pipeline of normalize, dot products,
// specular power and color. Depends on pvs_pkg.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_pos_*, i_norm_*, i_is_last
//  out     | output    | o_out_valid / i_out_ready  | o_red, o_green, o_blue, o_done_res
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One vertex enters per cycle while the output is not stalled; the 31-stage square
// root and the 31-stage restoring divider make one result bit per stage.
// Synchronous active-low reset clears all valid bits and the configuration registers.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
module phong_vertex_shader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_norm_x,
    input  logic [31:0] i_norm_y,
    input  logic [31:0] i_norm_z,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_red,
    output logic [15:0] o_green,
    output logic [15:0] o_blue,
    output logic        o_done_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);

    localparam int RW = pvs_pkg::ROOT_W;
    localparam int QW = pvs_pkg::QUO_W;
    localparam int WW = pvs_pkg::WIDE_W;

    logic        w_en;
    logic [31:0] r_light [3];
    logic [31:0] r_eye [3];
    logic [47:0] r_mat;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_light[c] <= '0;
                r_eye[c]   <= '0;
            end
            r_mat <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pvs_pkg::CFG_LIGHT_X:  r_light[0] <= i_cfg_data[31:0];
                pvs_pkg::CFG_LIGHT_Y:  r_light[1] <= i_cfg_data[31:0];
                pvs_pkg::CFG_LIGHT_Z:  r_light[2] <= i_cfg_data[31:0];
                pvs_pkg::CFG_EYE_X:    r_eye[0]   <= i_cfg_data[31:0];
                pvs_pkg::CFG_EYE_Y:    r_eye[1]   <= i_cfg_data[31:0];
                pvs_pkg::CFG_EYE_Z:    r_eye[2]   <= i_cfg_data[31:0];
                pvs_pkg::CFG_MATERIAL: r_mat      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits
    logic r_a_vld, r_b_vld, r_c_vld, r_u_vld, r_e_vld, r_f_vld, r_g_vld, r_h_vld;
    logic r_i_vld, r_j_vld, r_k1_vld, r_k2_vld, r_k3_vld;
    logic [RW:0] r_sq_vld;
    logic [QW:0] r_dv_vld;
    // last flag chains
    logic r_a_last, r_b_last, r_c_last, r_u_last, r_e_last, r_f_last, r_g_last, r_h_last;
    logic r_i_last, r_j_last, r_k1_last, r_k2_last, r_k3_last;
    logic [RW:0] r_sq_last;
    logic [QW:0] r_dv_last;

    // stage A: difference vectors
    logic signed [32:0] r_a_vec [3][3];
    logic [31:0] w_pos [3];
    logic [31:0] w_nrm [3];
    assign w_pos = '{i_pos_x, i_pos_y, i_pos_z};
    assign w_nrm = '{i_norm_x, i_norm_y, i_norm_z};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_last <= i_is_last;
            for (int c = 0; c < 3; c++) begin
                r_a_vec[0][c] <= $signed({r_light[c][31], r_light[c]})
                                 - $signed({w_pos[c][31], w_pos[c]});
                r_a_vec[1][c] <= $signed({r_eye[c][31], r_eye[c]})
                                 - $signed({w_pos[c][31], w_pos[c]});
                r_a_vec[2][c] <= $signed({w_nrm[c][31], w_nrm[c]});
            end
        end
    end

    // stage B: magnitudes, scaled below 2^30
    logic [29:0] r_b_mag [3][3];
    logic [2:0]  r_b_neg [3];
    logic [29:0] n_b_mag [3][3];

    always_comb begin
        logic [32:0] a [3];
        logic [32:0] o;
        logic [1:0]  sh;
        for (int v = 0; v < 3; v++) begin
            for (int c = 0; c < 3; c++)
                a[c] = r_a_vec[v][c][32] ? 33'(-r_a_vec[v][c]) : 33'(r_a_vec[v][c]);
            o = a[0] | a[1] | a[2];
            priority if (o[32]) sh = 2'd3;
            else if (o[31])     sh = 2'd2;
            else if (o[30])     sh = 2'd1;
            else                sh = 2'd0;
            for (int c = 0; c < 3; c++) n_b_mag[v][c] = 30'(a[c] >> sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_last <= r_a_last;
            for (int v = 0; v < 3; v++) begin
                for (int c = 0; c < 3; c++) begin
                    r_b_mag[v][c]    <= n_b_mag[v][c];
                    r_b_neg[v][c]    <= r_a_vec[v][c][32];
                end
            end
        end
    end

    // stage C: squares
    logic [59:0] r_c_sq [3][3];
    logic [29:0] r_c_mag [3][3];
    logic [2:0]  r_c_neg [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_last <= r_b_last;
            for (int v = 0; v < 3; v++) begin
                r_c_neg[v] <= r_b_neg[v];
                for (int c = 0; c < 3; c++) begin
                    r_c_sq[v][c]  <= 60'(r_b_mag[v][c]) * 60'(r_b_mag[v][c]);
                    r_c_mag[v][c] <= r_b_mag[v][c];
                end
            end
        end
    end

    // square root chain
    pvs_pkg::t_sqrt r_sq [RW+1];
    pvs_pkg::t_sqrt n_sq0;

    always_comb begin
        n_sq0 = '0;
        for (int v = 0; v < 3; v++) begin
            n_sq0.rem[v] = 62'(r_c_sq[v][0]) + 62'(r_c_sq[v][1]) + 62'(r_c_sq[v][2]);
            n_sq0.neg[v] = r_c_neg[v];
            for (int c = 0; c < 3; c++) n_sq0.mag[v][c] = r_c_mag[v][c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq[0]      <= n_sq0;
            r_sq_last[0] <= r_c_last;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int SB = RW - 1 - k;
        pvs_pkg::t_sqrt n_s;
        always_comb begin
            logic [62:0] trial;
            n_s = r_sq[k];
            for (int v = 0; v < 3; v++) begin
                trial = (63'(r_sq[k].root[v]) << (SB + 1)) + (63'd1 << (2 * SB));
                if ({1'b0, r_sq[k].rem[v]} >= trial) begin
                    n_s.rem[v]      = r_sq[k].rem[v] - trial[61:0];
                    n_s.root[v][SB] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[k+1]      <= n_s;
                r_sq_last[k+1] <= r_sq_last[k];
            end
        end
    end

    // divider chain
    pvs_pkg::t_div r_dv [QW+1];
    pvs_pkg::t_div n_dv0;

    always_comb begin
        n_dv0 = '0;
        for (int v = 0; v < 3; v++) begin
            n_dv0.len[v] = r_sq[RW].root[v];
            n_dv0.neg[v] = r_sq[RW].neg[v];
            for (int c = 0; c < 3; c++) n_dv0.rem[v][c] = {r_sq[RW].mag[v][c], 30'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv[0]      <= n_dv0;
            r_dv_last[0] <= r_sq_last[RW];
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int DB = QW - 1 - k;
        pvs_pkg::t_div n_d;
        always_comb begin
            logic [60:0] trial;
            n_d = r_dv[k];
            for (int v = 0; v < 3; v++) begin
                trial = 61'(r_dv[k].len[v]) << DB;
                for (int c = 0; c < 3; c++) begin
                    if ({1'b0, r_dv[k].rem[v][c]} >= trial) begin
                        n_d.rem[v][c]     = r_dv[k].rem[v][c] - trial[59:0];
                        n_d.quo[v][c][DB] = 1'b1;
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[k+1]      <= n_d;
                r_dv_last[k+1] <= r_dv_last[k];
            end
        end
    end

    // stage U: signed unit vectors, Q1.30
    logic signed [31:0] r_u [3][3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u_last <= r_dv_last[QW];
            for (int v = 0; v < 3; v++) begin
                for (int c = 0; c < 3; c++) begin
                    if (r_dv[QW].len[v] == '0)
                        r_u[v][c] <= '0;
                    else if (r_dv[QW].neg[v][c])
                        r_u[v][c] <= -$signed({1'b0, r_dv[QW].quo[v][c]});
                    else
                        r_u[v][c] <= $signed({1'b0, r_dv[QW].quo[v][c]});
                end
            end
        end
    end

    // stage E: N.L products
    logic signed [63:0] r_e_p [3];
    logic signed [31:0] r_e_ul [3];
    logic signed [31:0] r_e_uv [3];
    logic signed [31:0] r_e_un [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_last <= r_u_last;
            for (int c = 0; c < 3; c++) begin
                r_e_p[c]  <= r_u[2][c] * r_u[0][c];
                r_e_ul[c] <= r_u[0][c];
                r_e_uv[c] <= r_u[1][c];
                r_e_un[c] <= r_u[2][c];
            end
        end
    end

    // stage F: N.L sum
    logic signed [35:0] r_f_ndl;
    logic signed [31:0] r_f_ul [3];
    logic signed [31:0] r_f_uv [3];
    logic signed [31:0] r_f_un [3];
    logic signed [WW-1:0] n_f_ndl;

    assign n_f_ndl = pvs_pkg::drop30(WW'(r_e_p[0]) + WW'(r_e_p[1]) + WW'(r_e_p[2]));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_last <= r_e_last;
            r_f_ndl  <= n_f_ndl[35:0];
            r_f_ul   <= r_e_ul;
            r_f_uv   <= r_e_uv;
            r_f_un   <= r_e_un;
        end
    end

    // stage G: ndl * N
    logic signed [67:0] r_g_p [3];
    logic signed [35:0] r_g_ndl;
    logic signed [31:0] r_g_ul [3];
    logic signed [31:0] r_g_uv [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_last <= r_f_last;
            r_g_ndl  <= r_f_ndl;
            r_g_ul   <= r_f_ul;
            r_g_uv   <= r_f_uv;
            for (int c = 0; c < 3; c++) r_g_p[c] <= r_f_ndl * r_f_un[c];
        end
    end

    // stage H: reflection vector, diffuse term
    logic signed [39:0] r_h_rr [3];
    logic signed [31:0] r_h_uv [3];
    logic [pvs_pkg::UNIT_W-1:0] r_h_kd;
    logic signed [39:0] n_h_rr [3];

    always_comb begin
        logic signed [WW-1:0] d;
        for (int c = 0; c < 3; c++) begin
            d = pvs_pkg::drop30(WW'(r_g_p[c]));
            n_h_rr[c] = 40'(d[38:0]) * 40'sd2 - 40'(r_g_ul[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_last <= r_g_last;
            r_h_rr   <= n_h_rr;
            r_h_uv   <= r_g_uv;
            r_h_kd   <= pvs_pkg::clamp_unit(WW'(r_g_ndl));
        end
    end

    // stage I: V.R products
    logic signed [71:0] r_i_p [3];
    logic [pvs_pkg::UNIT_W-1:0] r_i_kd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_last <= r_h_last;
            r_i_kd   <= r_h_kd;
            for (int c = 0; c < 3; c++) r_i_p[c] <= r_h_uv[c] * r_h_rr[c];
        end
    end

    // stage J: specular base
    logic [pvs_pkg::UNIT_W-1:0] r_j_ks;
    logic [pvs_pkg::UNIT_W-1:0] r_j_kd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j_last <= r_i_last;
            r_j_kd   <= r_i_kd;
            r_j_ks   <= pvs_pkg::clamp_unit(pvs_pkg::drop30(
                            WW'(r_i_p[0]) + WW'(r_i_p[1]) + WW'(r_i_p[2])));
        end
    end

    // stages K1..K3: ks^8 and material times diffuse factor
    logic [61:0] r_k1_sq, r_k2_sq, r_k3_sq;
    logic [46:0] r_k1_mp [3];
    logic [46:0] r_k2_mp [3];
    logic [46:0] r_k3_mp [3];
    logic [30:0] w_factor;

    assign w_factor = (31'd1 << 29) + (r_j_kd >> 1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k1_last <= r_j_last;
            r_k1_sq   <= 62'(r_j_ks) * 62'(r_j_ks);
            for (int c = 0; c < 3; c++)
                r_k1_mp[c] <= 47'(r_mat[47 - 16 * c -: 16]) * 47'(w_factor);
            r_k2_last <= r_k1_last;
            r_k2_sq   <= 62'(r_k1_sq[61:30]) * 62'(r_k1_sq[61:30]);
            r_k2_mp   <= r_k1_mp;
            r_k3_last <= r_k2_last;
            r_k3_sq   <= 62'(r_k2_sq[61:30]) * 62'(r_k2_sq[61:30]);
            r_k3_mp   <= r_k2_mp;
        end
    end

    // output register: add specular, saturate
    logic [15:0] r_o_ch [3];
    logic        r_o_last;
    logic [15:0] n_o_ch [3];

    always_comb begin
        logic [16:0] s;
        for (int c = 0; c < 3; c++) begin
            s = 17'(r_k3_mp[c][46:32]) + 17'(r_k3_sq[61:46]);
            n_o_ch[c] = s[16] ? 16'hFFFF : s[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_ch   <= n_o_ch;
            r_o_last <= r_k3_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_c_vld  <= 1'b0;
            r_sq_vld <= '0;
            r_dv_vld <= '0;
            r_u_vld  <= 1'b0;
            r_e_vld  <= 1'b0;
            r_f_vld  <= 1'b0;
            r_g_vld  <= 1'b0;
            r_h_vld  <= 1'b0;
            r_i_vld  <= 1'b0;
            r_j_vld  <= 1'b0;
            r_k1_vld <= 1'b0;
            r_k2_vld <= 1'b0;
            r_k3_vld <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            r_a_vld  <= i_in_valid;
            r_b_vld  <= r_a_vld;
            r_c_vld  <= r_b_vld;
            r_sq_vld <= {r_sq_vld[RW-1:0], r_c_vld};
            r_dv_vld <= {r_dv_vld[QW-1:0], r_sq_vld[RW]};
            r_u_vld  <= r_dv_vld[QW];
            r_e_vld  <= r_u_vld;
            r_f_vld  <= r_e_vld;
            r_g_vld  <= r_f_vld;
            r_h_vld  <= r_g_vld;
            r_i_vld  <= r_h_vld;
            r_j_vld  <= r_i_vld;
            r_k1_vld <= r_j_vld;
            r_k2_vld <= r_k1_vld;
            r_k3_vld <= r_k2_vld;
            o_out_valid <= r_k3_vld;
        end
    end

    assign o_red      = r_o_ch[0];
    assign o_green    = r_o_ch[1];
    assign o_blue     = r_o_ch[2];
    assign o_done_res = r_o_last;

endmodule

### design/pvs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the Phong vertex shader, bound to the top level.
// No package dependencies.
module pvs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_red,
    input logic [15:0] o_green,
    input logic [15:0] o_blue,
    input logic        o_done_res
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_red) && $stable(o_green)
            && $stable(o_blue) && $stable(o_done_res))
        else $error("stalled transfer changed");

    a_ready_flow: assert property (@(posedge i_clk)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind phong_vertex_shader pvs_checker u_pvs_checker (.*);
